// ===== design/mecc_pkg.sv =====
package mecc_pkg;

    localparam int POS_W   = 16;
    localparam int SMP_W   = 12;
    localparam int PCT_W   = 7;
    localparam int PULSE_W = 4;
    localparam int CMD_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [SMP_W-1:0] t_smp;
    typedef logic [PCT_W-1:0] t_pct;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_TO_END   = 3'd1,
        PH_WAIT_LOW = 3'd2,
        PH_TO_START = 3'd3,
        PH_MOVING   = 3'd4,
        PH_READY    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    localparam logic [CMD_W-1:0] CMD_ON    = 8'h01;
    localparam logic [CMD_W-1:0] CMD_OFF   = 8'h02;
    localparam logic [CMD_W-1:0] CMD_HALT  = 8'h03;
    localparam logic [CMD_W-1:0] CMD_CALIB = 8'h04;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY  = 3'd4;

    localparam t_smp RST_LIMIT = 12'd2800;
    localparam t_pos RST_HOME  = 16'd1000;
    localparam t_pct RST_ON    = 7'd50;
    localparam t_pct RST_OFF   = 7'd10;
    localparam t_pct RST_DUTY  = 7'd50;

    // Divide by 100 as multiply by ceil(2^30 / 100), exact for products below 2^23
    localparam int PROD_W  = POS_W + PCT_W;
    localparam int RECIP_W = 24;
    localparam int SHIFT   = 30;
    localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
    localparam int QUOT_W  = PROD_W + RECIP_W - SHIFT;

    // Cycles the goal pipeline needs after marks or percentages change
    localparam logic [1:0] REFRESH_CYC = 2'd2;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;

endpackage

// ===== design/mecc_goal_calc.sv =====
module mecc_goal_calc (
    input  logic              i_clk,
    input  mecc_pkg::t_pos    i_start,
    input  mecc_pkg::t_pos    i_end,
    input  mecc_pkg::t_pct    i_on_pct,
    input  mecc_pkg::t_pct    i_off_pct,
    output mecc_pkg::t_pos    o_goal_on,
    output mecc_pkg::t_pos    o_goal_off
);

    mecc_pkg::t_pos                         stroke;
    logic [mecc_pkg::PROD_W-1:0]            r_prod_on;
    logic [mecc_pkg::PROD_W-1:0]            r_prod_off;
    mecc_pkg::t_pos                         r_start_d;
    logic [mecc_pkg::PROD_W+mecc_pkg::RECIP_W-1:0] scaled_on;
    logic [mecc_pkg::PROD_W+mecc_pkg::RECIP_W-1:0] scaled_off;
    logic [mecc_pkg::QUOT_W-1:0]            quot_on;
    logic [mecc_pkg::QUOT_W-1:0]            quot_off;
    mecc_pkg::t_pos                         r_goal_on;
    mecc_pkg::t_pos                         r_goal_off;

    // Stroke wraps when the end mark lies below the start mark
    assign stroke = i_end - i_start;

    always_ff @(posedge i_clk) begin
        r_prod_on  <= mecc_pkg::PROD_W'(stroke) * mecc_pkg::PROD_W'(i_on_pct);
        r_prod_off <= mecc_pkg::PROD_W'(stroke) * mecc_pkg::PROD_W'(i_off_pct);
        r_start_d  <= i_start;
    end

    assign scaled_on  = (mecc_pkg::PROD_W+mecc_pkg::RECIP_W)'(r_prod_on)
                        * (mecc_pkg::PROD_W+mecc_pkg::RECIP_W)'(mecc_pkg::RECIP);
    assign scaled_off = (mecc_pkg::PROD_W+mecc_pkg::RECIP_W)'(r_prod_off)
                        * (mecc_pkg::PROD_W+mecc_pkg::RECIP_W)'(mecc_pkg::RECIP);
    assign quot_on  = scaled_on[mecc_pkg::PROD_W+mecc_pkg::RECIP_W-1:mecc_pkg::SHIFT];
    assign quot_off = scaled_off[mecc_pkg::PROD_W+mecc_pkg::RECIP_W-1:mecc_pkg::SHIFT];

    always_ff @(posedge i_clk) begin
        r_goal_on  <= r_start_d + quot_on[mecc_pkg::POS_W-1:0];
        r_goal_off <= r_start_d + quot_off[mecc_pkg::POS_W-1:0];
    end

    assign o_goal_on  = r_goal_on;
    assign o_goal_off = r_goal_off;

endmodule

// ===== design/motor_endstop_calibration_controller_unit.sv =====
// Motor end-stop calibration controller. Each stream transaction is one control tick
// (current sample, hall pulses, command); each tick yields one status transaction in the
// following cycle, and a new tick is taken every cycle while the output is drained. The
// move targets start + stroke * percent / 100 come from a two-stage goal pipeline, so
// o_s_tready drops while it refreshes after reset, after a mark changes (calibrate
// command, end or start found) and after any register write. Position wraps at 16 bits.
module motor_endstop_calibration_controller_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: current_sample[11:0], hall_pulses[15:12], cmd_code[23:16]
    input  logic [mecc_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: sample_ready[0], cmd_valid[1]
    input  logic [mecc_pkg::IN_USER_W-1:0]     i_s_tuser,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: drive_dir[1:0], drive_enable[2], pwm_compare[9:3], position_now[25:10],
    // phase_now[28:26], start_mark[44:29], end_mark[60:45], goal_position[76:61],
    // calibrated[77], zero[79:78]
    output logic [mecc_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic                               i_cfg_we,
    input  logic [mecc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mecc_pkg::CFG_W-1:0]         i_cfg_data
);

    // configuration
    mecc_pkg::t_smp   r_limit;
    mecc_pkg::t_pos   r_home;
    mecc_pkg::t_pct   r_on_pct;
    mecc_pkg::t_pct   r_off_pct;
    mecc_pkg::t_pct   r_duty;

    // controller state
    mecc_pkg::t_phase r_phase,  n_phase;
    mecc_pkg::t_dir   r_dir,    n_dir;
    mecc_pkg::t_pos   r_pos,    n_pos;
    mecc_pkg::t_pos   r_start,  n_start;
    mecc_pkg::t_pos   r_end,    n_end;
    mecc_pkg::t_pos   r_goal,   n_goal;
    logic             r_cal,    n_cal;
    logic             r_moved,  n_moved;
    logic             r_low,    n_low;
    mecc_pkg::t_smp   r_held,   n_held;

    logic [1:0]       r_refresh;
    logic             r_out_valid;
    logic [mecc_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    mecc_pkg::t_pos   goal_on;
    mecc_pkg::t_pos   goal_off;

    logic             in_fire;
    logic             out_free;
    logic             marks_change;

    logic             sample_ready;
    logic             cmd_valid;
    mecc_pkg::t_smp   sample;
    logic [mecc_pkg::PULSE_W-1:0] pulses;
    logic [mecc_pkg::CMD_W-1:0]   cmd;

    logic             start_move;
    logic             high;
    logic             pos_lt;
    logic             pos_gt;
    logic             drive_en;
    mecc_pkg::t_pct   pwm;

    assign sample       = i_s_tdata[11:0];
    assign pulses       = i_s_tdata[15:12];
    assign cmd          = i_s_tdata[23:16];
    assign sample_ready = i_s_tuser[0];
    assign cmd_valid    = i_s_tuser[1];

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = out_free && (r_refresh == 2'd0);
    assign in_fire    = i_s_tvalid && o_s_tready;

    mecc_goal_calc u_goal_calc (
        .i_clk      (i_clk),
        .i_start    (r_start),
        .i_end      (r_end),
        .i_on_pct   (r_on_pct),
        .i_off_pct  (r_off_pct),
        .o_goal_on  (goal_on),
        .o_goal_off (goal_off)
    );

    always_comb begin
        n_held  = sample_ready ? sample : r_held;
        n_pos   = r_pos;
        n_moved = r_moved;
        n_phase = r_phase;
        n_dir   = r_dir;
        n_start = r_start;
        n_end   = r_end;
        n_goal  = r_goal;
        n_cal   = r_cal;
        n_low   = r_low;
        start_move = 1'b0;

        // apply hall pulses in the present direction; pulses count as movement anyway
        if (pulses != '0) begin
            if (r_dir == mecc_pkg::DIR_CCW) begin
                n_pos = r_pos + mecc_pkg::t_pos'(pulses);
            end else if (r_dir == mecc_pkg::DIR_CW) begin
                n_pos = r_pos - mecc_pkg::t_pos'(pulses);
            end
            n_moved = 1'b1;
        end

        if (cmd_valid) begin
            case (cmd)
                mecc_pkg::CMD_ON: begin
                    if (r_cal) begin
                        start_move = 1'b1;
                        n_goal     = goal_on;
                    end
                end
                mecc_pkg::CMD_OFF: begin
                    if (r_cal) begin
                        start_move = 1'b1;
                        n_goal     = goal_off;
                    end
                end
                mecc_pkg::CMD_HALT: begin
                    n_dir   = mecc_pkg::DIR_STOP;
                    n_phase = mecc_pkg::PH_IDLE;
                end
                mecc_pkg::CMD_CALIB: begin
                    n_pos   = r_home;
                    n_start = '0;
                    n_end   = '0;
                    n_goal  = '0;
                    n_cal   = 1'b0;
                    n_moved = 1'b0;
                    n_low   = 1'b0;
                    n_phase = mecc_pkg::PH_TO_END;
                    n_dir   = mecc_pkg::DIR_CCW;
                end
                default: begin
                end
            endcase
        end

        pos_lt = n_pos < n_goal;
        pos_gt = n_pos > n_goal;

        if (start_move) begin
            n_phase = mecc_pkg::PH_MOVING;
            if (pos_lt) begin
                n_dir = mecc_pkg::DIR_CCW;
            end else if (pos_gt) begin
                n_dir = mecc_pkg::DIR_CW;
            end else begin
                n_dir   = mecc_pkg::DIR_STOP;
                n_phase = mecc_pkg::PH_READY;
            end
        end

        // calibration: end stop counts only after movement and a low reading in this leg
        high = n_held >= r_limit;
        if (n_phase == mecc_pkg::PH_TO_END || n_phase == mecc_pkg::PH_TO_START) begin
            if (high) begin
                if (n_moved && n_low) begin
                    if (n_phase == mecc_pkg::PH_TO_END) begin
                        n_end   = n_pos;
                        n_phase = mecc_pkg::PH_WAIT_LOW;
                    end else begin
                        n_start = n_pos;
                        n_cal   = 1'b1;
                        n_phase = mecc_pkg::PH_READY;
                    end
                    n_dir = mecc_pkg::DIR_STOP;
                end
            end else if (n_moved) begin
                n_low = 1'b1;
            end
        end else if (n_phase == mecc_pkg::PH_WAIT_LOW && !high) begin
            n_moved = 1'b0;
            n_low   = 1'b0;
            n_phase = mecc_pkg::PH_TO_START;
            n_dir   = mecc_pkg::DIR_CW;
        end

        // a move begun this tick cannot already be at its goal
        if (n_phase == mecc_pkg::PH_MOVING && !start_move) begin
            if ((n_dir == mecc_pkg::DIR_CCW && !pos_lt) ||
                (n_dir == mecc_pkg::DIR_CW && !pos_gt)) begin
                n_dir   = mecc_pkg::DIR_STOP;
                n_phase = mecc_pkg::PH_READY;
            end
        end

        drive_en = n_dir != mecc_pkg::DIR_STOP;
        pwm      = drive_en ? r_duty : '0;
        n_out_data = {2'b00, n_cal, n_goal, n_end, n_start, n_phase, n_pos,
                      pwm, drive_en, n_dir};
    end

    assign marks_change = in_fire && ((n_start != r_start) || (n_end != r_end));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= mecc_pkg::RST_LIMIT;
            r_home    <= mecc_pkg::RST_HOME;
            r_on_pct  <= mecc_pkg::RST_ON;
            r_off_pct <= mecc_pkg::RST_OFF;
            r_duty    <= mecc_pkg::RST_DUTY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mecc_pkg::CFG_LIMIT: r_limit   <= i_cfg_data[mecc_pkg::SMP_W-1:0];
                mecc_pkg::CFG_HOME:  r_home    <= i_cfg_data[mecc_pkg::POS_W-1:0];
                mecc_pkg::CFG_ON:    r_on_pct  <= i_cfg_data[mecc_pkg::PCT_W-1:0];
                mecc_pkg::CFG_OFF:   r_off_pct <= i_cfg_data[mecc_pkg::PCT_W-1:0];
                mecc_pkg::CFG_DUTY:  r_duty    <= i_cfg_data[mecc_pkg::PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mecc_pkg::PH_IDLE;
            r_dir   <= mecc_pkg::DIR_STOP;
            r_pos   <= mecc_pkg::RST_HOME;
            r_start <= '0;
            r_end   <= '0;
            r_goal  <= '0;
            r_cal   <= 1'b0;
            r_moved <= 1'b0;
            r_low   <= 1'b0;
            r_held  <= '0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_dir   <= n_dir;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_end   <= n_end;
            r_goal  <= n_goal;
            r_cal   <= n_cal;
            r_moved <= n_moved;
            r_low   <= n_low;
            r_held  <= n_held;
        end
    end

    // hold off new ticks until the goal pipeline has caught up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refresh <= mecc_pkg::REFRESH_CYC;
        end else if (marks_change || i_cfg_we) begin
            r_refresh <= mecc_pkg::REFRESH_CYC;
        end else if (r_refresh != 2'd0) begin
            r_refresh <= r_refresh - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== sim/tb_motor_endstop_calibration_controller_unit.sv =====
`timescale 1ns / 100ps

module tb_motor_endstop_calibration_controller_unit;

    typedef struct packed {
        logic           cmd_valid;
        logic [7:0]     cmd;
        logic [3:0]     pulses;
        logic           smp_ready;
        mecc_pkg::t_smp smp;
    } t_tick;

    // status transaction, lowest field last
    typedef struct packed {
        logic [1:0]       pad;
        logic             cal;
        mecc_pkg::t_pos   goal;
        mecc_pkg::t_pos   end_m;
        mecc_pkg::t_pos   start_m;
        mecc_pkg::t_phase ph;
        mecc_pkg::t_pos   pos;
        mecc_pkg::t_pct   pwm;
        logic             en;
        mecc_pkg::t_dir   dir;
    } t_status;

    class endstop_predictor;
        mecc_pkg::t_smp   limit_r;
        mecc_pkg::t_pos   home_r;
        mecc_pkg::t_pct   on_r;
        mecc_pkg::t_pct   off_r;
        mecc_pkg::t_pct   duty_r;
        mecc_pkg::t_phase ph;
        mecc_pkg::t_dir   dir;
        mecc_pkg::t_pos   pos;
        mecc_pkg::t_pos   start_m;
        mecc_pkg::t_pos   end_m;
        mecc_pkg::t_pos   goal;
        bit               cal;
        bit               moved;
        bit               low_seen;
        mecc_pkg::t_smp   held;
        t_status          status_due[$];
        int unsigned      mismatches;

        function new();
            limit_r    = mecc_pkg::RST_LIMIT;
            home_r     = mecc_pkg::RST_HOME;
            on_r       = mecc_pkg::RST_ON;
            off_r      = mecc_pkg::RST_OFF;
            duty_r     = mecc_pkg::RST_DUTY;
            ph         = mecc_pkg::PH_IDLE;
            dir        = mecc_pkg::DIR_STOP;
            pos        = mecc_pkg::RST_HOME;
            start_m    = '0;
            end_m      = '0;
            goal       = '0;
            cal        = 1'b0;
            moved      = 1'b0;
            low_seen   = 1'b0;
            held       = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [mecc_pkg::CFG_IDX_W-1:0] idx,
                                logic [mecc_pkg::CFG_W-1:0] data);
            case (idx)
                mecc_pkg::CFG_LIMIT: limit_r = data[mecc_pkg::SMP_W-1:0];
                mecc_pkg::CFG_HOME:  home_r  = data[mecc_pkg::POS_W-1:0];
                mecc_pkg::CFG_ON:    on_r    = data[mecc_pkg::PCT_W-1:0];
                mecc_pkg::CFG_OFF:   off_r   = data[mecc_pkg::PCT_W-1:0];
                mecc_pkg::CFG_DUTY:  duty_r  = data[mecc_pkg::PCT_W-1:0];
                default: ;
            endcase
        endfunction

        function void aim(mecc_pkg::t_pct pct);
            logic [31:0] span;
            logic [31:0] share;
            // stroke wraps at the position width when the end lies below the start
            span  = 32'(mecc_pkg::t_pos'(end_m - start_m));
            share = (span * 32'(pct)) / 32'd100;
            goal  = mecc_pkg::t_pos'(32'(start_m) + share);
            ph    = mecc_pkg::PH_MOVING;
            if (pos < goal) begin
                dir = mecc_pkg::DIR_CCW;
            end else if (pos > goal) begin
                dir = mecc_pkg::DIR_CW;
            end else begin
                dir = mecc_pkg::DIR_STOP;
                ph  = mecc_pkg::PH_READY;
            end
        endfunction

        function void note_tick(t_tick t);
            bit      high;
            t_status exp;
            if (t.smp_ready) held = t.smp;
            if (t.pulses != 4'd0) begin
                if (dir == mecc_pkg::DIR_CCW) begin
                    pos = pos + mecc_pkg::t_pos'(t.pulses);
                end else if (dir == mecc_pkg::DIR_CW) begin
                    pos = pos - mecc_pkg::t_pos'(t.pulses);
                end
                moved = 1'b1;
            end
            if (t.cmd_valid) begin
                if (t.cmd == mecc_pkg::CMD_ON && cal) begin
                    aim(on_r);
                end else if (t.cmd == mecc_pkg::CMD_OFF && cal) begin
                    aim(off_r);
                end else if (t.cmd == mecc_pkg::CMD_HALT) begin
                    dir = mecc_pkg::DIR_STOP;
                    ph  = mecc_pkg::PH_IDLE;
                end else if (t.cmd == mecc_pkg::CMD_CALIB) begin
                    pos      = home_r;
                    start_m  = '0;
                    end_m    = '0;
                    goal     = '0;
                    cal      = 1'b0;
                    moved    = 1'b0;
                    low_seen = 1'b0;
                    ph       = mecc_pkg::PH_TO_END;
                    dir      = mecc_pkg::DIR_CCW;
                end
            end
            high = (held >= limit_r);
            if (ph == mecc_pkg::PH_TO_END || ph == mecc_pkg::PH_TO_START) begin
                if (high) begin
                    // an end stop counts only after movement and a low reading
                    if (moved && low_seen) begin
                        if (ph == mecc_pkg::PH_TO_END) begin
                            end_m = pos;
                            ph    = mecc_pkg::PH_WAIT_LOW;
                        end else begin
                            start_m = pos;
                            cal     = 1'b1;
                            ph      = mecc_pkg::PH_READY;
                        end
                        dir = mecc_pkg::DIR_STOP;
                    end
                end else if (moved) begin
                    low_seen = 1'b1;
                end
            end else if (ph == mecc_pkg::PH_WAIT_LOW && !high) begin
                moved    = 1'b0;
                low_seen = 1'b0;
                ph       = mecc_pkg::PH_TO_START;
                dir      = mecc_pkg::DIR_CW;
            end
            if (ph == mecc_pkg::PH_MOVING &&
                ((dir == mecc_pkg::DIR_CCW && pos >= goal) ||
                 (dir == mecc_pkg::DIR_CW && pos <= goal))) begin
                dir = mecc_pkg::DIR_STOP;
                ph  = mecc_pkg::PH_READY;
            end
            exp         = '0;
            exp.dir     = dir;
            exp.en      = (dir != mecc_pkg::DIR_STOP);
            exp.pwm     = exp.en ? duty_r : '0;
            exp.pos     = pos;
            exp.ph      = ph;
            exp.start_m = start_m;
            exp.end_m   = end_m;
            exp.goal    = goal;
            exp.cal     = cal;
            status_due.push_back(exp);
        endfunction

        function void compare_field(string fld, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                mismatches++;
                $display("%0t: %s expected %0d actual %0d", $time, fld, e, a);
            end
        endfunction

        function void check_status(t_status act);
            t_status exp;
            if (status_due.size() == 0) begin
                mismatches++;
                $display("%0t: status transaction with none expected, expected none actual %h",
                         $time, act);
                return;
            end
            exp = status_due.pop_front();
            compare_field("drive_dir", 32'(exp.dir), 32'(act.dir));
            compare_field("drive_enable", 32'(exp.en), 32'(act.en));
            compare_field("pwm_compare", 32'(exp.pwm), 32'(act.pwm));
            compare_field("position_now", 32'(exp.pos), 32'(act.pos));
            compare_field("phase_now", 32'(exp.ph), 32'(act.ph));
            compare_field("start_mark", 32'(exp.start_m), 32'(act.start_m));
            compare_field("end_mark", 32'(exp.end_m), 32'(act.end_m));
            compare_field("goal_position", 32'(exp.goal), 32'(act.goal));
            compare_field("calibrated", 32'(exp.cal), 32'(act.cal));
            compare_field("padding", 32'(exp.pad), 32'(act.pad));
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic [mecc_pkg::IN_DATA_W-1:0]     i_s_tdata = '0;
    logic [mecc_pkg::IN_USER_W-1:0]     i_s_tuser = '0;
    logic                               i_s_tvalid = 1'b0;
    logic                               o_s_tready;
    logic [mecc_pkg::OUT_DATA_W-1:0]    o_m_tdata;
    logic                               o_m_tvalid;
    logic                               i_m_tready = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [mecc_pkg::CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [mecc_pkg::CFG_W-1:0]         i_cfg_data = '0;

    endstop_predictor sb = new();
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;

    motor_endstop_calibration_controller_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_tick mk(int unsigned rdy, int unsigned smp, int unsigned pls,
                                 int unsigned cv, logic [7:0] code);
        t_tick t;
        t.smp_ready = (rdy != 0);
        t.smp       = mecc_pkg::t_smp'(smp);
        t.pulses    = 4'(pls);
        t.cmd_valid = (cv != 0);
        t.cmd       = code;
        return t;
    endfunction

    function automatic mecc_pkg::t_smp lo_sample();
        if (sb.limit_r == 0) return mecc_pkg::t_smp'($urandom);
        return mecc_pkg::t_smp'($urandom_range(0, sb.limit_r - 1));
    endfunction

    function automatic mecc_pkg::t_smp hi_sample();
        return mecc_pkg::t_smp'($urandom_range(sb.limit_r, 4095));
    endfunction

    // Shape the tick on the predicted phase so that calibrations and moves complete
    function automatic t_tick make_tick();
        t_tick t;
        int    r;
        t.smp       = mecc_pkg::t_smp'($urandom);
        t.smp_ready = 1'($urandom_range(0, 1));
        t.pulses    = 4'($urandom_range(0, 15));
        t.cmd       = 8'($urandom_range(0, 255));
        t.cmd_valid = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            t.cmd_valid = 1'($urandom_range(0, 1));
            return t;
        end
        case (sb.ph)
            mecc_pkg::PH_IDLE: begin
                if (r < 45) begin
                    t.cmd_valid = 1'b1;
                    t.cmd       = mecc_pkg::CMD_CALIB;
                end else if (r < 70) begin
                    t.cmd_valid = 1'b1;
                    t.cmd       = $urandom_range(0, 1) ? mecc_pkg::CMD_ON : mecc_pkg::CMD_OFF;
                end
            end
            mecc_pkg::PH_TO_END, mecc_pkg::PH_TO_START: begin
                t.smp_ready = (r < 85);
                t.smp       = ($urandom_range(0, 3) == 0) ? hi_sample() : lo_sample();
                if (r >= 97) begin
                    t.cmd_valid = 1'b1;
                    t.cmd       = mecc_pkg::CMD_HALT;
                end
            end
            mecc_pkg::PH_WAIT_LOW: begin
                t.smp_ready = 1'b1;
                t.smp       = $urandom_range(0, 1) ? lo_sample() : hi_sample();
            end
            mecc_pkg::PH_MOVING: begin
                if (r < 16) begin
                    t.cmd_valid = 1'b1;
                    t.cmd       = mecc_pkg::CMD_HALT;
                end else if (r < 22) begin
                    t.cmd_valid = 1'b1;
                    t.cmd       = $urandom_range(0, 1) ? mecc_pkg::CMD_ON : mecc_pkg::CMD_OFF;
                end
            end
            default: begin
                if (r < 50) begin
                    t.cmd_valid = 1'b1;
                    t.cmd       = $urandom_range(0, 1) ? mecc_pkg::CMD_ON : mecc_pkg::CMD_OFF;
                end else if (r < 54) begin
                    t.cmd_valid = 1'b1;
                    t.cmd       = mecc_pkg::CMD_HALT;
                end else if (r < 58) begin
                    t.cmd_valid = 1'b1;
                    t.cmd       = mecc_pkg::CMD_CALIB;
                end
            end
        endcase
        return t;
    endfunction

    // Hold the tick until the block takes it; valid is left high for the caller
    task automatic send_tick(t_tick t);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {t.cmd, t.pulses, t.smp};
        i_s_tuser  <= {t.cmd_valid, t.smp_ready};
        do begin
            @(negedge i_clk);
            taken = o_s_tready;
            @(posedge i_clk);
        end while (!taken);
        sb.note_tick(t);
    endtask

    task automatic cfg_write(logic [mecc_pkg::CFG_IDX_W-1:0] idx,
                             logic [mecc_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic drain();
        while (sb.status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(int unsigned lim, int unsigned home, int unsigned on_pct,
                             int unsigned off_pct, int unsigned duty, int mode, int n);
        drain();
        cfg_write(mecc_pkg::CFG_LIMIT, mecc_pkg::CFG_W'(lim));
        cfg_write(mecc_pkg::CFG_HOME, mecc_pkg::CFG_W'(home));
        cfg_write(mecc_pkg::CFG_ON, mecc_pkg::CFG_W'(on_pct));
        cfg_write(mecc_pkg::CFG_OFF, mecc_pkg::CFG_W'(off_pct));
        cfg_write(mecc_pkg::CFG_DUTY, mecc_pkg::CFG_W'(duty));
        i_cfg_we <= 1'b0;
        case (mode)
            0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_idle_pct = 57; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 57; end
            default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
        endcase
        repeat (n) send_tick(make_tick());
        i_s_tvalid <= 1'b0;
    endtask

    // status side: decide tready at the edge, take the transaction mid-cycle
    initial begin
        forever begin
            @(posedge i_clk);
            i_m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            @(negedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_status(o_m_tdata);
        end
    end

    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_tick plan[$];
        plan.push_back(mk(0, 0, 0, 0, 8'h00));
        plan.push_back(mk(1, 4095, 15, 0, 8'hFF));
        plan.push_back(mk(0, 0, 0, 1, mecc_pkg::CMD_ON));
        plan.push_back(mk(0, 0, 0, 1, mecc_pkg::CMD_OFF));
        plan.push_back(mk(0, 0, 0, 1, 8'hFF));
        plan.push_back(mk(0, 0, 0, 1, 8'h00));
        plan.push_back(mk(0, 0, 0, 1, mecc_pkg::CMD_HALT));
        plan.push_back(mk(1, 0, 0, 1, mecc_pkg::CMD_CALIB));
        plan.push_back(mk(1, 2799, 4, 0, 8'h00));
        plan.push_back(mk(1, 2800, 1, 0, 8'h00));
        plan.push_back(mk(1, 4095, 2, 0, 8'h00));
        plan.push_back(mk(1, 0, 0, 0, 8'h00));
        // clockwise past zero: start mark ends up above the end mark
        plan.push_back(mk(0, 4095, 15, 0, 8'h00));
        plan.push_back(mk(1, 4095, 0, 0, 8'h00));
        plan.push_back(mk(0, 0, 0, 1, mecc_pkg::CMD_ON));
        plan.push_back(mk(0, 0, 15, 0, 8'h00));
        plan.push_back(mk(0, 0, 0, 1, mecc_pkg::CMD_OFF));
        plan.push_back(mk(0, 0, 0, 1, mecc_pkg::CMD_HALT));
        plan.push_back(mk(0, 0, 0, 1, mecc_pkg::CMD_OFF));
        plan.push_back(mk(0, 0, 15, 0, 8'h00));
        plan.push_back(mk(0, 0, 1, 0, 8'h00));
        plan.push_back(mk(0, 0, 0, 1, mecc_pkg::CMD_OFF));
        plan.push_back(mk(0, 0, 7, 1, mecc_pkg::CMD_CALIB));
        plan.push_back(mk(1, 4095, 0, 1, mecc_pkg::CMD_HALT));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_write(mecc_pkg::CFG_HOME, mecc_pkg::CFG_W'(5));
        i_cfg_we <= 1'b0;
        foreach (plan[k]) send_tick(plan[k]);
        i_s_tvalid <= 1'b0;

        run_phase(2800, 1000, 50, 10, 50, 0, 70);
        run_phase(4095, 65535, 100, 0, 99, 1, 70);
        run_phase(0, 0, 0, 100, 0, 2, 70);
        run_phase(1, 65530, 127, 127, 1, 3, 70);
        run_phase($urandom_range(200, 3800), $urandom_range(0, 65535),
                  $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 99), 0, 70);
        run_phase(2048, 32768, 75, 25, 33, 1, 70);
        run_phase($urandom_range(200, 3800), $urandom_range(0, 65535),
                  $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 99), 2, 70);
        run_phase($urandom_range(200, 3800), $urandom_range(0, 65535),
                  $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 99), 3, 70);

        drain();
        repeat (6) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.status_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
